// ===== rtl/hsec_pkg.sv =====
// ----------------------------------------------------------------------------
// hsec_pkg
// Shared widths, request codes, stage payload types and the fixed wiring
// functions of the Hamming single-error-correcting encoder and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hsec_pkg;

    localparam int CODE_BITS = 63;
    localparam int DATA_BITS = 57;
    localparam int POS_W     = 6;
    localparam int CFG_W     = 6;
    localparam int PAR_BITS  = 6;

    localparam logic [CFG_W-1:0] DATA_BITS_RESET = 6'd4;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_CHECK  = 1'b1;

    typedef struct packed {
        logic                 req;
        logic [CODE_BITS-1:0] word;
    } t_s1;

    typedef struct packed {
        logic                 req;
        logic [CODE_BITS-1:0] word;
        logic [POS_W-1:0]     syn;
    } t_s2;

    // Codeword length n = m + r, with m limited so that n fits the codeword.
    function automatic logic [POS_W-1:0] code_len(input logic [CFG_W-1:0] data_bits);
        logic [CFG_W:0] m;
        logic [CFG_W:0] r;
        m = {1'b0, data_bits};
        r = '0;
        if (m > (CFG_W+1)'(DATA_BITS)) begin
            m = (CFG_W+1)'(DATA_BITS);
        end
        for (int i = 0; i <= PAR_BITS; i++) begin
            if (((CFG_W+1)'(1) << r) < (m + r + (CFG_W+1)'(1))) begin
                r = r + (CFG_W+1)'(1);
            end
        end
        return POS_W'(m + r);
    endfunction

    // Bit i of the mask is set for codeword position i+1 when i+1 <= n.
    function automatic logic [CODE_BITS-1:0] pos_mask(input logic [POS_W-1:0] n);
        logic [CODE_BITS-1:0] mask;
        for (int i = 0; i < CODE_BITS; i++) begin
            mask[i] = (POS_W'(i) < n);
        end
        return mask;
    endfunction

    // Data bits go to the positions that are not powers of two, in rising order.
    function automatic logic [CODE_BITS-1:0] spread_data(input logic [DATA_BITS-1:0] data);
        logic [CODE_BITS-1:0] cw;
        logic [POS_W-1:0]     p;
        int                   d;
        cw = '0;
        d  = 0;
        for (int i = 0; i < CODE_BITS; i++) begin
            p = POS_W'(i + 1);
            if ((p & (p - POS_W'(1))) != '0) begin
                cw[i] = data[POS_W'(d)];
                d     = d + 1;
            end
        end
        return cw;
    endfunction

    // Syndrome bit k is the parity of every position whose number has bit k set.
    function automatic logic [POS_W-1:0] syndrome(input logic [CODE_BITS-1:0] word);
        logic [POS_W-1:0]     syn;
        logic [CODE_BITS-1:0] col;
        logic [POS_W-1:0]     p;
        for (int k = 0; k < POS_W; k++) begin
            for (int i = 0; i < CODE_BITS; i++) begin
                p      = POS_W'(i + 1);
                col[i] = p[k];
            end
            syn[k] = ^(word & col);
        end
        return syn;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hamming_sec_encode_check_top.sv =====
// ----------------------------------------------------------------------------
// hamming_sec_encode_check_top
// Hamming single-error-correcting encoder and syndrome checker with a
// configurable number of data bits.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while no stall holds it and
// passes each through its three register stages in order: input selection
// and masking to the configured codeword length, the syndrome XOR trees, and
// output formatting with parity insertion. Back-pressure on the output stalls
// the stages behind it without loss; empty stages still accept. The data
// width register is 4 after reset and values above 57 act as 57; write it
// only while no transaction is in flight.
`default_nettype none

module hamming_sec_encode_check_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [hsec_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_req_type,
    input  wire logic [hsec_pkg::DATA_BITS-1:0]  i_data_word,
    input  wire logic [hsec_pkg::CODE_BITS-1:0]  i_code_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [hsec_pkg::CODE_BITS-1:0]       o_encoded_word,
    output logic [hsec_pkg::POS_W-1:0]           o_error_position,
    output logic                                 o_error_found
);

    logic [hsec_pkg::CODE_BITS-1:0] r_pos_mask;
    logic [hsec_pkg::CODE_BITS-1:0] n_pos_mask;

    logic          r_s1_valid;
    logic          n_s1_valid;
    hsec_pkg::t_s1 r_s1;
    hsec_pkg::t_s1 n_s1;

    logic          syn_ready;
    logic          syn_valid;
    hsec_pkg::t_s2 syn_s2;

    logic                           out_ready;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic [hsec_pkg::CODE_BITS-1:0] r_encoded_word;
    logic [hsec_pkg::CODE_BITS-1:0] n_encoded_word;
    logic [hsec_pkg::POS_W-1:0]     r_error_position;
    logic [hsec_pkg::POS_W-1:0]     n_error_position;
    logic                           r_error_found;
    logic                           n_error_found;

    // The length mask is derived once per register write.
    assign o_cfg_ready = 1'b1;
    assign n_pos_mask  = (i_cfg_valid) ?
                         hsec_pkg::pos_mask(hsec_pkg::code_len(i_cfg_data)) : r_pos_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_mask <= hsec_pkg::pos_mask(hsec_pkg::code_len(hsec_pkg::DATA_BITS_RESET));
        end else begin
            r_pos_mask <= n_pos_mask;
        end
    end

    // Stage one: place data bits or take the received word, then cut to length.
    assign o_in_ready = !r_s1_valid || syn_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1       = r_s1;
        if (o_in_ready) begin
            n_s1_valid = i_in_valid;
            n_s1.req   = i_req_type;
            if (i_req_type == hsec_pkg::REQ_ENCODE) begin
                n_s1.word = hsec_pkg::spread_data(i_data_word) & r_pos_mask;
            end else begin
                n_s1.word = i_code_word & r_pos_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
        r_s1 <= n_s1;
    end

    hsec_syn u_syn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (syn_ready),
        .i_s1    (r_s1),
        .o_valid (syn_valid),
        .i_ready (out_ready),
        .o_s2    (syn_s2)
    );

    // Stage three: in encode mode the syndrome of the data positions gives the
    // parity bits, which sit at the power-of-two positions.
    assign out_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid      = r_out_valid;
        n_encoded_word   = r_encoded_word;
        n_error_position = r_error_position;
        n_error_found    = r_error_found;
        if (out_ready) begin
            n_out_valid = syn_valid;
            if (syn_s2.req == hsec_pkg::REQ_ENCODE) begin
                n_encoded_word = syn_s2.word;
                for (int k = 0; k < hsec_pkg::PAR_BITS; k++) begin
                    n_encoded_word[(1 << k) - 1] = syn_s2.syn[k];
                end
                n_error_position = '0;
                n_error_found    = 1'b0;
            end else begin
                n_encoded_word   = '0;
                n_error_position = syn_s2.syn;
                n_error_found    = (syn_s2.syn != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_encoded_word   <= n_encoded_word;
        r_error_position <= n_error_position;
        r_error_found    <= n_error_found;
    end

    assign o_out_valid      = r_out_valid;
    assign o_encoded_word   = r_encoded_word;
    assign o_error_position = r_error_position;
    assign o_error_found    = r_error_found;

    a_found_has_position : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_found |-> o_error_position != '0)
        else $error("error flagged with a zero syndrome");

    a_modes_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_encoded_word != '0 |-> !o_error_found && o_error_position == '0)
        else $error("codeword and check result present together");

    a_empty_accepts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("empty first stage refuses a transaction");

    a_accept_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_s1_valid)
        else $error("accepted transaction lost in the first stage");

endmodule

`default_nettype wire

// ===== rtl/hsec_syn.sv =====
// ----------------------------------------------------------------------------
// hsec_syn
// Middle pipeline stage: the six XOR trees that form the syndrome of the
// masked codeword, with its own valid bit and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module hsec_syn (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire hsec_pkg::t_s1 i_s1,
    output logic              o_valid,
    input  wire logic         i_ready,
    output hsec_pkg::t_s2     o_s2
);

    logic          r_valid;
    logic          n_valid;
    hsec_pkg::t_s2 r_s2;
    hsec_pkg::t_s2 n_s2;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_s2    = r_s2;
        if (o_ready) begin
            n_valid   = i_valid;
            n_s2.req  = i_s1.req;
            n_s2.word = i_s1.word;
            n_s2.syn  = hsec_pkg::syndrome(i_s1.word);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_s2 <= n_s2;
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

`default_nettype wire
